// ===== hw/rtl/b32e_pkg.sv =====
// Package for the base32 stream encoder: field widths, group mask and the
// character mapping. Depends on nothing.
`timescale 1ns / 1ps
package b32e_pkg;

    localparam int BYTE_W  = 8;
    localparam int SYM_W   = 7;
    localparam int GROUP_W = 5;
    localparam int LEFT_W  = 4;
    localparam int CNT_W   = 3;

    localparam logic [GROUP_W-1:0] GROUP_MASK = 5'h1F;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [GROUP_W-1:0] group_t;

    localparam sym_t CHAR_A    = 7'h41;
    localparam sym_t CHAR_TWO  = 7'h32;
    localparam group_t LETTERS = 5'd26;

    // Map a 5-bit group to its character: A-Z, then 2-7.
    function automatic sym_t sym_of(input group_t group);
        group_t g;
        sym_t   s;
        g = group & GROUP_MASK;
        if (g < LETTERS)
        begin
            s = CHAR_A + sym_t'(g);
        end
        else
        begin
            s = CHAR_TWO + sym_t'(g - LETTERS);
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/b32e_if.sv =====
// Stream channels of the base32 stream encoder: byte channel and character
// channel. Depends on b32e_pkg.
`timescale 1ns / 1ps
interface b32e_msg_if;
    logic              valid;
    logic              ready;
    b32e_pkg::byte_t   data_byte;
    logic              final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32e_enc_if;
    logic              valid;
    logic              ready;
    b32e_pkg::sym_t    symbol;
    logic              symbol_last;

    modport source (output valid, output symbol, output symbol_last, input ready);
    modport sink   (input valid, input symbol, input symbol_last, output ready);
endinterface

// ===== hw/rtl/base32_stream_encoder.sv =====
// Base32 stream encoder top level: byte beats in, character beats out.
// Depends on b32e_pkg and the channel interfaces in b32e_if.sv.
`timescale 1ns / 1ps
// Encodes a byte stream into base32 characters (A-Z, 2-7) without '='
// padding. Each accepted byte beat yields one or two characters; the beat
// flagged final_byte also flushes any leftover bits as one zero-filled
// character, and symbol_last marks the final character of the message.
// All encoding for a byte is done in the accept cycle into a three-entry
// character buffer, which drains through an output register at one
// character per cycle while the sink is ready. A new byte is taken when the
// buffer is empty or is giving up its last character in that cycle, so the
// next byte can be taken while the last character of the previous one moves
// to the output register. The output register lets the input keep accepting
// while a finished character waits for the sink.
module base32_stream_encoder
(
    input logic      clk,
    input logic      rst_n,
    b32e_msg_if.sink msg,
    b32e_enc_if.source enc
);
    import b32e_pkg::*;

    // leftover state between bytes
    logic [LEFT_W-1:0] leftover_bits_reg;
    logic [CNT_W-1:0]  leftover_count_reg;

    // character buffer: entry 0 goes out next
    sym_t       buf_sym_reg [3];
    logic [1:0] buf_cnt_reg;
    logic       buf_fin_reg;

    // output register
    logic out_valid_reg;
    sym_t symbol_reg;
    logic symbol_last_reg;

    logic out_take;
    logic move;
    logic accept;

    // encode path
    logic [LEFT_W-1:0] lo_mask;
    logic [LEFT_W-1:0] lo;
    logic [11:0]       win;
    logic [CNT_W-1:0]  shamt;
    logic [CNT_W-1:0]  rem;
    logic [1:0]        n_reg_grp;
    logic [1:0]        n_total;
    logic [LEFT_W-1:0] rem_mask;
    sym_t              sym0;
    sym_t              sym1;
    sym_t              sym2;

    assign out_take = !out_valid_reg || enc.ready;
    assign move     = (buf_cnt_reg != 2'd0) && out_take;
    assign msg.ready = (buf_cnt_reg == 2'd0) || ((buf_cnt_reg == 2'd1) && out_take);
    assign accept   = msg.valid && msg.ready;

    assign enc.valid       = out_valid_reg;
    assign enc.symbol      = symbol_reg;
    assign enc.symbol_last = symbol_last_reg;

    always_comb
    begin
        lo_mask = LEFT_W'((5'd1 << leftover_count_reg) - 5'd1);
        lo      = leftover_bits_reg & lo_mask;
        shamt   = CNT_W'(3'd4 - leftover_count_reg);
        // left-align the held bits and the new byte at the top of a 12-bit window
        win     = {lo, msg.data_byte} << shamt;
        unique case (leftover_count_reg)
            3'd0:    begin rem = 3'd3; n_reg_grp = 2'd1; end
            3'd1:    begin rem = 3'd4; n_reg_grp = 2'd1; end
            3'd2:    begin rem = 3'd0; n_reg_grp = 2'd2; end
            3'd3:    begin rem = 3'd1; n_reg_grp = 2'd2; end
            default: begin rem = 3'd2; n_reg_grp = 2'd2; end
        endcase
        n_total  = n_reg_grp + 2'((msg.final_byte && (rem != 3'd0)) ? 1 : 0);
        rem_mask = LEFT_W'((5'd1 << rem) - 5'd1);
        // the second slot is either a full group or the zero-filled flush
        sym0 = sym_of(win[11:7]);
        sym1 = sym_of(win[6:2]);
        sym2 = sym_of({win[1:0], 3'b000});
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= '0;
            leftover_count_reg <= '0;
            buf_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (msg.final_byte)
                begin
                    // flush: clear the leftover
                    leftover_bits_reg  <= '0;
                    leftover_count_reg <= '0;
                end
                else
                begin
                    leftover_bits_reg  <= msg.data_byte[LEFT_W-1:0] & rem_mask;
                    leftover_count_reg <= rem;
                end
                buf_cnt_reg <= n_total;
            end
            else if (move)
            begin
                buf_cnt_reg <= buf_cnt_reg - 2'd1;
            end
            if (out_take)
            begin
                out_valid_reg <= (buf_cnt_reg != 2'd0);
            end
        end
    end

    // payload: buffer entries and output character
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_sym_reg[0] <= sym0;
            buf_sym_reg[1] <= sym1;
            buf_sym_reg[2] <= sym2;
            buf_fin_reg    <= msg.final_byte;
        end
        else if (move)
        begin
            // advance the buffer by one entry
            buf_sym_reg[0] <= buf_sym_reg[1];
            buf_sym_reg[1] <= buf_sym_reg[2];
        end
        if (move)
        begin
            symbol_reg      <= buf_sym_reg[0];
            symbol_last_reg <= buf_fin_reg && (buf_cnt_reg == 2'd1);
        end
    end

    // leftover count stays within one partial group
    a_left_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        leftover_count_reg <= 3'd4)
        else $error("leftover count out of range");

    // a final byte leaves no leftover behind
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && msg.final_byte) |=> (leftover_count_reg == 3'd0))
        else $error("leftover not cleared after final byte");

    // every accepted byte leaves at least one character in the buffer
    a_buf_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (buf_cnt_reg != 2'd0))
        else $error("accepted byte produced no character");

    // only alphabet characters reach the output
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((symbol_reg >= 7'h32 && symbol_reg <= 7'h37) ||
                           (symbol_reg >= 7'h41 && symbol_reg <= 7'h5A)))
        else $error("output character outside base32 alphabet");

endmodule
